// ----- sv/ledmc_pkg.sv -----
package ledmc_pkg;

	// payload widths
	localparam int ACT_W       = 2;
	localparam int BYTE_W      = 8;
	localparam int TC_W        = 15;
	localparam int PINS_W      = 6;
	localparam int MODE_W      = 4;
	localparam int LEVEL_W     = 15;
	localparam int FADE_STEP_W = 10;
	localparam int CYC_STEP_W  = 11;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 11;

	localparam int CMD_LEN_DEF = 8;

	// item kinds
	localparam logic [ACT_W-1:0] ACT_BYTE    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_TICK    = 2'd1;
	localparam logic [ACT_W-1:0] ACT_REFRESH = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FADE_STEP  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CYCLE_STEP = 1'd1;

	localparam logic [FADE_STEP_W-1:0] FADE_STEP_RST  = 10'd200;
	localparam logic [CYC_STEP_W-1:0]  CYCLE_STEP_RST = 11'd250;

	// display modes
	localparam logic [MODE_W-1:0] MODE_OFF             = 4'd0;
	localparam logic [MODE_W-1:0] MODE_RED_BREATH      = 4'd1;
	localparam logic [MODE_W-1:0] MODE_RED             = 4'd2;
	localparam logic [MODE_W-1:0] MODE_YELLOW          = 4'd3;
	localparam logic [MODE_W-1:0] MODE_LIGHT_BLUE      = 4'd4;
	localparam logic [MODE_W-1:0] MODE_GREEN_BREATH    = 4'd5;
	localparam logic [MODE_W-1:0] MODE_GREEN           = 4'd6;
	localparam logic [MODE_W-1:0] MODE_CYCLE           = 4'd7;
	localparam logic [MODE_W-1:0] MODE_CUSTOM          = 4'd8;
	localparam logic [MODE_W-1:0] MODE_RED_BREATH_ALT  = 4'd9;
	localparam logic [MODE_W-1:0] MODE_MAX             = 4'd9;

	// pin patterns
	localparam logic [PINS_W-1:0] PINS_OFF    = 6'h00;
	localparam logic [PINS_W-1:0] PINS_RED    = 6'h03;
	localparam logic [PINS_W-1:0] PINS_GREEN  = 6'h0C;
	localparam logic [PINS_W-1:0] PINS_YELLOW = 6'h0F;
	localparam logic [PINS_W-1:0] PINS_ALL    = 6'h3F;
	localparam logic [PINS_W-1:0] PINS_PURPLE = 6'h33;

	// fade and cycle limits
	localparam logic [LEVEL_W-1:0] FADE_SAT     = 15'd32767;
	localparam logic [LEVEL_W-1:0] FADE_TOP     = 15'd19990;
	localparam logic [LEVEL_W-1:0] FADE_BOTTOM  = 15'd1000;
	localparam logic [LEVEL_W-1:0] CYC_LIMIT    = 15'd20000;
	localparam int                 CYC_PERIOD   = 2000;
	localparam int                 CYC_SEGS     = 10;

	// characters and words
	localparam logic [BYTE_W-1:0] CH_X = 8'h78;
	localparam logic [BYTE_W-1:0] CH_Z = 8'h7A;
	localparam logic [BYTE_W-1:0] CH_C = 8'h63;
	localparam logic [BYTE_W-1:0] CH_U = 8'h75;
	localparam logic [BYTE_W-1:0] CH_0 = 8'h30;
	localparam logic [BYTE_W-1:0] CH_1 = 8'h31;
	localparam logic [BYTE_W-1:0] CH_7 = 8'h37;
	localparam logic [BYTE_W-1:0] CH_9 = 8'h39;

	localparam logic [63:0] WORD_FWD  = "forwards";
	localparam logic [63:0] WORD_BWD  = "backward";
	localparam logic [47:0] WORD_MODE = "mode00";

	// decoded command, valid in the cycle of the 'z' beat
	typedef struct packed {
		logic              fwd;
		logic              bwd;
		logic              set_mode;
		logic [MODE_W-1:0] mode_val;
		logic              clr_cycle;
		logic              set_custom;
		logic [PINS_W-1:0] pattern;
	} cmd_t;

	function automatic logic [MODE_W-1:0] mode_step(input logic [MODE_W-1:0] m,
		input logic up);
		if (up) begin
			return (m >= MODE_MAX) ? MODE_OFF : m + 4'd1;
		end
		return (m == MODE_OFF || m > MODE_MAX) ? MODE_MAX : m - 4'd1;
	endfunction

	// colour cycle: red, all, all, yellow, purple, twice over
	function automatic logic [PINS_W-1:0] cycle_seg(input logic [3:0] seg);
		case (seg)
			4'd0, 4'd5: return PINS_RED;
			4'd1, 4'd2, 4'd6, 4'd7: return PINS_ALL;
			4'd3, 4'd8: return PINS_YELLOW;
			4'd4, 4'd9: return PINS_PURPLE;
			default: return PINS_OFF;
		endcase
	endfunction

endpackage

// ----- sv/ledmc_if.sv -----
interface ledmc_req_if;
	logic                             valid;
	logic                             ready;
	logic [ledmc_pkg::ACT_W-1:0]      action;
	logic [ledmc_pkg::BYTE_W-1:0]     rx_byte;
	logic [ledmc_pkg::TC_W-1:0]       timer_count;
	logic                             button_left;
	logic                             button_right;

	modport source (output valid, action, rx_byte, timer_count, button_left, button_right,
		input ready);
	modport sink (input valid, action, rx_byte, timer_count, button_left, button_right,
		output ready);
endinterface

interface ledmc_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [ledmc_pkg::PINS_W-1:0]     led_pins;
	logic [ledmc_pkg::MODE_W-1:0]     current_mode;

	modport source (output valid, led_pins, current_mode, input ready);
	modport sink (input valid, led_pins, current_mode, output ready);
endinterface

interface ledmc_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [ledmc_pkg::CFG_IDX_W-1:0]  index;
	logic [ledmc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/ledmc_cmd.sv -----
module ledmc_cmd #(
	parameter int CMD_LEN = ledmc_pkg::CMD_LEN_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         byte_en,
	input  logic [ledmc_pkg::BYTE_W-1:0] rx_byte,
	output ledmc_pkg::cmd_t              cmd
);
	localparam int IDX_W = $clog2(CMD_LEN + 1);
	localparam int AW    = $clog2(CMD_LEN);
	localparam logic [IDX_W-1:0] LEN_I = IDX_W'(CMD_LEN);

	logic [ledmc_pkg::BYTE_W-1:0] buf_q [CMD_LEN];
	logic [IDX_W-1:0]             idx_q;

	logic               is_exec;
	logic [CMD_LEN-1:0] nonterm;
	logic [CMD_LEN-1:0] prefix;
	logic               len8;
	logic               fwd_hit;
	logic               bwd_hit;
	logic               mode_hit;
	logic               cu_hit;
	logic [ledmc_pkg::BYTE_W-1:0] digit;

	assign is_exec = byte_en && (rx_byte == ledmc_pkg::CH_Z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CMD_LEN; k++) buf_q[k] <= '0;
			idx_q <= '0;
		end else if (is_exec) begin
			for (int k = 0; k < CMD_LEN; k++) buf_q[k] <= '0;
			idx_q <= '0;
		end else if (byte_en) begin
			if (idx_q < LEN_I) begin
				buf_q[idx_q[AW-1:0]] <= rx_byte;
			end
			if (rx_byte == ledmc_pkg::CH_X) begin
				idx_q <= '0;
			end else if (idx_q < LEN_I) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// text runs up to the first zero or 'z'
	always_comb begin
		for (int k = 0; k < CMD_LEN; k++) begin
			nonterm[k] = (buf_q[k] != '0) && (buf_q[k] != ledmc_pkg::CH_Z);
		end
		prefix[0] = nonterm[0];
		for (int k = 1; k < CMD_LEN; k++) begin
			prefix[k] = prefix[k-1] & nonterm[k];
		end
	end

	generate
		if (CMD_LEN > 8) begin : g_long
			assign len8 = prefix[7] && !nonterm[8];
		end else begin : g_exact
			assign len8 = prefix[7];
		end
	endgenerate

	always_comb begin
		fwd_hit = 1'b1;
		bwd_hit = 1'b1;
		mode_hit = 1'b1;
		for (int k = 0; k < 8; k++) begin
			fwd_hit &= (buf_q[k] == ledmc_pkg::WORD_FWD[8*(7-k) +: 8]);
			bwd_hit &= (buf_q[k] == ledmc_pkg::WORD_BWD[8*(7-k) +: 8]);
		end
		for (int k = 0; k < 6; k++) begin
			mode_hit &= (buf_q[k] == ledmc_pkg::WORD_MODE[8*(5-k) +: 8]);
		end
		mode_hit &= ((buf_q[6] == ledmc_pkg::CH_0) && (buf_q[7] >= ledmc_pkg::CH_0)
			&& (buf_q[7] <= ledmc_pkg::CH_9))
			|| ((buf_q[6] == ledmc_pkg::CH_1) && (buf_q[7] == ledmc_pkg::CH_0));
		cu_hit = (buf_q[0] == ledmc_pkg::CH_C) && (buf_q[1] == ledmc_pkg::CH_U);
		digit = buf_q[7] - ledmc_pkg::CH_0;

		cmd.fwd = is_exec && len8 && fwd_hit;
		cmd.bwd = is_exec && len8 && bwd_hit;
		cmd.set_mode = is_exec && len8 && mode_hit;
		// "mode0010" wraps to off
		cmd.mode_val = (buf_q[6] == ledmc_pkg::CH_1) ? ledmc_pkg::MODE_OFF : digit[3:0];
		cmd.clr_cycle = (buf_q[6] == ledmc_pkg::CH_0) && (buf_q[7] == ledmc_pkg::CH_7);
		cmd.set_custom = is_exec && cu_hit;
		for (int i = 0; i < ledmc_pkg::PINS_W; i++) begin
			cmd.pattern[i] = (buf_q[2+i] == ledmc_pkg::CH_1) && prefix[2+i];
		end
	end

endmodule

// ----- sv/ledmc_render.sv -----
module ledmc_render (
	input  logic [ledmc_pkg::MODE_W-1:0]  mode,
	input  logic [ledmc_pkg::TC_W-1:0]    timer_count,
	input  logic [ledmc_pkg::LEVEL_W-1:0] fade_level,
	input  logic [ledmc_pkg::LEVEL_W-1:0] cycle_time,
	input  logic [ledmc_pkg::PINS_W-1:0]  custom_pattern,
	output logic [ledmc_pkg::PINS_W-1:0]  pins
);
	logic                          breath_on;
	logic [3:0]                    seg;
	logic                          seg_edge;
	logic [ledmc_pkg::PINS_W-1:0]  cyc_pins;

	assign breath_on = timer_count > fade_level;

	// segment number by threshold compares, dark on every boundary
	always_comb begin
		seg = '0;
		seg_edge = (cycle_time == '0) || (cycle_time >= ledmc_pkg::CYC_LIMIT);
		for (int k = 1; k < ledmc_pkg::CYC_SEGS; k++) begin
			if (cycle_time >= ledmc_pkg::LEVEL_W'(k * ledmc_pkg::CYC_PERIOD)) begin
				seg = 4'(k);
			end
			if (cycle_time == ledmc_pkg::LEVEL_W'(k * ledmc_pkg::CYC_PERIOD)) begin
				seg_edge = 1'b1;
			end
		end
		cyc_pins = seg_edge ? ledmc_pkg::PINS_OFF : ledmc_pkg::cycle_seg(seg);
	end

	always_comb begin
		unique case (mode) inside
			ledmc_pkg::MODE_RED_BREATH, ledmc_pkg::MODE_RED_BREATH_ALT:
				pins = breath_on ? ledmc_pkg::PINS_RED : ledmc_pkg::PINS_OFF;
			ledmc_pkg::MODE_RED:          pins = ledmc_pkg::PINS_RED;
			ledmc_pkg::MODE_YELLOW:       pins = ledmc_pkg::PINS_YELLOW;
			ledmc_pkg::MODE_LIGHT_BLUE:   pins = ledmc_pkg::PINS_ALL;
			ledmc_pkg::MODE_GREEN_BREATH:
				pins = breath_on ? ledmc_pkg::PINS_GREEN : ledmc_pkg::PINS_OFF;
			ledmc_pkg::MODE_GREEN:        pins = ledmc_pkg::PINS_GREEN;
			ledmc_pkg::MODE_CYCLE:        pins = cyc_pins;
			ledmc_pkg::MODE_CUSTOM:       pins = custom_pattern;
			default:                      pins = ledmc_pkg::PINS_OFF;
		endcase
	end

endmodule

// ----- sv/led_mode_controller_with_serial_commands_core.sv -----
// a request beat is held in the input register, then in the state and result registers
//   that carry its result beat
// throughput: one item per cycle unless results stall; the input register refills in
//   the cycle the result register drains, so a stall holds at most two items in flight
// reset (arst_n low): mode off, pins off, fade level 0 rising, cycle time 0, command buffer
//   and index cleared, fade_step 200, cycle_step 250
module led_mode_controller_with_serial_commands_core #(
	parameter int CMD_LEN = ledmc_pkg::CMD_LEN_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	ledmc_req_if.sink    req,
	ledmc_rsp_if.source  rsp,
	ledmc_cfg_if.sink    cfg
);
	// input stage
	logic                            valid_s1;
	logic [ledmc_pkg::ACT_W-1:0]     act_s1;
	logic [ledmc_pkg::BYTE_W-1:0]    rx_s1;
	logic [ledmc_pkg::TC_W-1:0]      tc_s1;
	logic                            bl_s1;
	logic                            br_s1;

	// block state; pin and mode registers double as the result payload
	logic [ledmc_pkg::MODE_W-1:0]    mode_q;
	logic [ledmc_pkg::PINS_W-1:0]    pins_q;
	logic [ledmc_pkg::PINS_W-1:0]    custom_q;
	logic [ledmc_pkg::LEVEL_W-1:0]   fade_q;
	logic                            rising_q;
	logic [ledmc_pkg::LEVEL_W-1:0]   cycle_q;
	logic                            hold_left_q;
	logic                            hold_right_q;
	logic                            out_valid_q;

	// configuration
	logic [ledmc_pkg::FADE_STEP_W-1:0] fade_step_q;
	logic [ledmc_pkg::CYC_STEP_W-1:0]  cycle_step_q;

	logic                            adv;
	ledmc_pkg::cmd_t                 cmd;
	logic [ledmc_pkg::MODE_W-1:0]    mode_left;
	logic [ledmc_pkg::MODE_W-1:0]    mode_btn;
	logic [ledmc_pkg::PINS_W-1:0]    render_pins;
	logic [ledmc_pkg::LEVEL_W-1:0]   cyc_base;
	logic [ledmc_pkg::LEVEL_W:0]     cyc_sum;
	logic [ledmc_pkg::LEVEL_W-1:0]   cyc_next;
	logic [ledmc_pkg::LEVEL_W:0]     fade_sum;
	logic [ledmc_pkg::LEVEL_W-1:0]   fade_step_w;
	logic [ledmc_pkg::LEVEL_W-1:0]   fade_next;
	logic                            rising_next;

	// the item in the input stage commits when the result register is free or drains now
	assign adv       = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;
	assign cfg.ready = 1'b1;

	assign rsp.valid        = out_valid_q;
	assign rsp.led_pins     = pins_q;
	assign rsp.current_mode = mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			act_s1 <= req.action;
			rx_s1  <= req.rx_byte;
			tc_s1  <= req.timer_count;
			bl_s1  <= req.button_left;
			br_s1  <= req.button_right;
		end
	end

	// serial command buffer and decoder
	ledmc_cmd #(
		.CMD_LEN (CMD_LEN)
	) u_cmd (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_en (adv && (act_s1 == ledmc_pkg::ACT_BYTE)),
		.rx_byte (rx_s1),
		.cmd     (cmd)
	);

	// buttons: left steps down first, then right steps up; the pins are drawn for the
	// mode after both, which matches drawing before and redrawing after a step
	always_comb begin
		mode_left = (bl_s1 && !hold_left_q) ? ledmc_pkg::mode_step(mode_q, 1'b0) : mode_q;
		mode_btn  = (br_s1 && !hold_right_q) ? ledmc_pkg::mode_step(mode_left, 1'b1)
			: mode_left;
	end

	ledmc_render u_render (
		.mode           (mode_btn),
		.timer_count    (tc_s1),
		.fade_level     (fade_q),
		.cycle_time     (cycle_q),
		.custom_pattern (custom_q),
		.pins           (render_pins)
	);

	// period tick: cycle time restarts at its limit and saturates there,
	// fade level moves as a triangle between the turn points
	always_comb begin
		cyc_base = (cycle_q == ledmc_pkg::CYC_LIMIT) ? '0 : cycle_q;
		cyc_sum  = {1'b0, cyc_base} + (ledmc_pkg::LEVEL_W + 1)'(cycle_step_q);
		cyc_next = (cyc_sum > {1'b0, ledmc_pkg::CYC_LIMIT}) ? ledmc_pkg::CYC_LIMIT
			: cyc_sum[ledmc_pkg::LEVEL_W-1:0];

		fade_step_w = ledmc_pkg::LEVEL_W'(fade_step_q);
		fade_sum    = {1'b0, fade_q} + {1'b0, fade_step_w};
		if (rising_q) begin
			fade_next = fade_sum[ledmc_pkg::LEVEL_W] ? ledmc_pkg::FADE_SAT
				: fade_sum[ledmc_pkg::LEVEL_W-1:0];
		end else begin
			fade_next = (fade_q < fade_step_w) ? '0 : fade_q - fade_step_w;
		end
		rising_next = rising_q;
		if (fade_next > ledmc_pkg::FADE_TOP) rising_next = 1'b0;
		if (fade_next < ledmc_pkg::FADE_BOTTOM) rising_next = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= ledmc_pkg::MODE_OFF;
			pins_q       <= ledmc_pkg::PINS_OFF;
			custom_q     <= '0;
			fade_q       <= '0;
			rising_q     <= 1'b1;
			cycle_q      <= '0;
			hold_left_q  <= 1'b0;
			hold_right_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// a committed item loads the result, a taken beat frees it
			out_valid_q <= adv || (out_valid_q && !rsp.ready);
			if (adv) begin
				unique case (act_s1)
					ledmc_pkg::ACT_BYTE: begin
						if (cmd.fwd) mode_q <= ledmc_pkg::mode_step(mode_q, 1'b1);
						if (cmd.bwd) mode_q <= ledmc_pkg::mode_step(mode_q, 1'b0);
						if (cmd.set_mode) begin
							mode_q <= cmd.mode_val;
							if (cmd.clr_cycle) cycle_q <= '0;
						end
						if (cmd.set_custom) begin
							mode_q   <= ledmc_pkg::MODE_CUSTOM;
							custom_q <= cmd.pattern;
						end
					end
					ledmc_pkg::ACT_TICK: begin
						cycle_q  <= cyc_next;
						fade_q   <= fade_next;
						rising_q <= rising_next;
					end
					ledmc_pkg::ACT_REFRESH: begin
						mode_q       <= mode_btn;
						pins_q       <= render_pins;
						// a held level keeps its hold, a released one clears it
						hold_left_q  <= bl_s1;
						hold_right_q <= br_s1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_step_q  <= ledmc_pkg::FADE_STEP_RST;
			cycle_step_q <= ledmc_pkg::CYCLE_STEP_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				ledmc_pkg::REG_FADE_STEP:  fade_step_q  <= cfg.data[ledmc_pkg::FADE_STEP_W-1:0];
				ledmc_pkg::REG_CYCLE_STEP: cycle_step_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q <= ledmc_pkg::MODE_MAX)
		else $error("display mode out of range");

	a_cycle_range: assert property (@(posedge clk) disable iff (!arst_n)
		cycle_q <= ledmc_pkg::CYC_LIMIT)
		else $error("cycle time above limit");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (valid_s1 && out_valid_q && !rsp.ready))
		else $error("input held off without a stalled result");

	a_hold_track: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && act_s1 == ledmc_pkg::ACT_REFRESH) |=>
		(hold_left_q == $past(bl_s1) && hold_right_q == $past(br_s1)))
		else $error("button hold does not follow refresh level");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

localparam int CMD_TEXT_LEN = ledmc_pkg::CMD_LEN_DEF;

typedef struct packed {
	logic [ledmc_pkg::ACT_W-1:0]  action;
	logic [ledmc_pkg::BYTE_W-1:0] rx_byte;
	logic [ledmc_pkg::TC_W-1:0]   timer_count;
	logic                         button_left;
	logic                         button_right;
} led_request_t;

typedef struct packed {
	logic [ledmc_pkg::PINS_W-1:0] pins;
	logic [ledmc_pkg::MODE_W-1:0] mode;
} led_view_t;

localparam int REQ_W = $bits(led_request_t);

class led_mode_scoreboard;
	led_view_t                    expected_views[$];
	logic [ledmc_pkg::BYTE_W-1:0] cmd_buf [CMD_TEXT_LEN];
	int unsigned                  buf_fill;
	logic [ledmc_pkg::MODE_W-1:0] mode;
	logic [ledmc_pkg::PINS_W-1:0] custom_pins;
	logic [ledmc_pkg::PINS_W-1:0] pins;
	int unsigned                  fade_level;
	bit                           fade_rising;
	int unsigned                  cycle_time;
	bit                           held_left;
	bit                           held_right;
	int unsigned                  fade_step;
	int unsigned                  cycle_step;
	int                           errors;
	int                           results_seen;
	int                           requests_seen;

	function new();
		foreach (cmd_buf[i]) cmd_buf[i] = '0;
		buf_fill = 0;
		mode = ledmc_pkg::MODE_OFF;
		custom_pins = ledmc_pkg::PINS_OFF;
		pins = ledmc_pkg::PINS_OFF;
		fade_level = 0;
		fade_rising = 1'b1;
		cycle_time = 0;
		held_left = 1'b0;
		held_right = 1'b0;
		fade_step = 32'(ledmc_pkg::FADE_STEP_RST);
		cycle_step = 32'(ledmc_pkg::CYCLE_STEP_RST);
		errors = 0;
		results_seen = 0;
		requests_seen = 0;
	endfunction

	function void set_register(logic [ledmc_pkg::CFG_IDX_W-1:0] idx,
		logic [ledmc_pkg::CFG_DATA_W-1:0] value);
		if (idx == ledmc_pkg::REG_FADE_STEP) begin
			fade_step = 32'(value[ledmc_pkg::FADE_STEP_W-1:0]);
		end else begin
			cycle_step = 32'(value[ledmc_pkg::CYC_STEP_W-1:0]);
		end
	endfunction

	function logic [ledmc_pkg::MODE_W-1:0] step_mode(logic [ledmc_pkg::MODE_W-1:0] m, bit up);
		if (up) begin
			return (m == ledmc_pkg::MODE_MAX) ? ledmc_pkg::MODE_OFF : m + 1'b1;
		end
		return (m == ledmc_pkg::MODE_OFF) ? ledmc_pkg::MODE_MAX : m - 1'b1;
	endfunction

	// five colour segments per half of the cycle, dark on every segment boundary
	function logic [ledmc_pkg::PINS_W-1:0] cycle_colour(int unsigned t);
		int unsigned seg;
		if (t == 0 || t >= ledmc_pkg::CYC_LIMIT || t % ledmc_pkg::CYC_PERIOD == 0) begin
			return ledmc_pkg::PINS_OFF;
		end
		seg = (t / ledmc_pkg::CYC_PERIOD) % (ledmc_pkg::CYC_SEGS / 2);
		case (seg)
			0: return ledmc_pkg::PINS_RED;
			1, 2: return ledmc_pkg::PINS_ALL;
			3: return ledmc_pkg::PINS_YELLOW;
			default: return ledmc_pkg::PINS_PURPLE;
		endcase
	endfunction

	function logic [ledmc_pkg::PINS_W-1:0] render_pins(int unsigned tc);
		case (mode)
			ledmc_pkg::MODE_RED_BREATH, ledmc_pkg::MODE_RED_BREATH_ALT:
				return (tc > fade_level) ? ledmc_pkg::PINS_RED : ledmc_pkg::PINS_OFF;
			ledmc_pkg::MODE_RED: return ledmc_pkg::PINS_RED;
			ledmc_pkg::MODE_YELLOW: return ledmc_pkg::PINS_YELLOW;
			ledmc_pkg::MODE_LIGHT_BLUE: return ledmc_pkg::PINS_ALL;
			ledmc_pkg::MODE_GREEN_BREATH:
				return (tc > fade_level) ? ledmc_pkg::PINS_GREEN : ledmc_pkg::PINS_OFF;
			ledmc_pkg::MODE_GREEN: return ledmc_pkg::PINS_GREEN;
			ledmc_pkg::MODE_CYCLE: return cycle_colour(cycle_time);
			ledmc_pkg::MODE_CUSTOM: return custom_pins;
			default: return ledmc_pkg::PINS_OFF;
		endcase
	endfunction

	// text ends at the first zero, the first 'z' or the end of the buffer
	function void run_command();
		logic [ledmc_pkg::BYTE_W-1:0] txt [CMD_TEXT_LEN];
		logic [63:0]                  word;
		logic [ledmc_pkg::PINS_W-1:0] pat;
		int unsigned                  len;
		int unsigned                  val;
		foreach (txt[i]) txt[i] = '0;
		len = 0;
		while (len < CMD_TEXT_LEN && cmd_buf[len] != 8'h00 && cmd_buf[len] != ledmc_pkg::CH_Z)
		begin
			txt[len] = cmd_buf[len];
			len++;
		end
		word = {txt[0], txt[1], txt[2], txt[3], txt[4], txt[5], txt[6], txt[7]};
		if (len == 8 && word == ledmc_pkg::WORD_FWD) begin
			mode = step_mode(mode, 1'b1);
		end else if (len == 8 && word == ledmc_pkg::WORD_BWD) begin
			mode = step_mode(mode, 1'b0);
		end else if (len == 8 && word[63:16] == ledmc_pkg::WORD_MODE &&
				((txt[6] == ledmc_pkg::CH_0 && txt[7] >= ledmc_pkg::CH_0 &&
				txt[7] <= ledmc_pkg::CH_9) ||
				(txt[6] == ledmc_pkg::CH_1 && txt[7] == ledmc_pkg::CH_0))) begin
			val = (txt[6] == ledmc_pkg::CH_1) ? 10 : 32'(txt[7] - ledmc_pkg::CH_0);
			mode = (val > ledmc_pkg::MODE_MAX) ? ledmc_pkg::MODE_OFF : ledmc_pkg::MODE_W'(val);
			if (val == ledmc_pkg::MODE_CYCLE) cycle_time = 0;
		end else if (len >= 2 && txt[0] == ledmc_pkg::CH_C && txt[1] == ledmc_pkg::CH_U) begin
			pat = ledmc_pkg::PINS_OFF;
			for (int i = 0; i < ledmc_pkg::PINS_W; i++) begin
				if (txt[2 + i] == ledmc_pkg::CH_1) pat[i] = 1'b1;
			end
			custom_pins = pat;
			mode = ledmc_pkg::MODE_CUSTOM;
		end
		foreach (cmd_buf[i]) cmd_buf[i] = '0;
		buf_fill = 0;
	endfunction

	function void advance_timers();
		if (cycle_time == ledmc_pkg::CYC_LIMIT) cycle_time = 0;
		cycle_time = (cycle_time + cycle_step > ledmc_pkg::CYC_LIMIT) ?
			32'(ledmc_pkg::CYC_LIMIT) : cycle_time + cycle_step;
		if (fade_rising) begin
			fade_level = (fade_level + fade_step > ledmc_pkg::FADE_SAT) ?
				32'(ledmc_pkg::FADE_SAT) : fade_level + fade_step;
		end else begin
			fade_level = (fade_level < fade_step) ? 0 : fade_level - fade_step;
		end
		if (fade_level > ledmc_pkg::FADE_TOP) fade_rising = 1'b0;
		if (fade_level < ledmc_pkg::FADE_BOTTOM) fade_rising = 1'b1;
	endfunction

	function void note_request(led_request_t rq);
		bit stepped;
		stepped = 1'b0;
		requests_seen++;
		case (rq.action)
			ledmc_pkg::ACT_BYTE: begin
				if (rq.rx_byte == ledmc_pkg::CH_Z) begin
					run_command();
				end else begin
					if (buf_fill < CMD_TEXT_LEN) begin
						cmd_buf[buf_fill] = rq.rx_byte;
						if (rq.rx_byte != ledmc_pkg::CH_X) buf_fill++;
					end
					if (rq.rx_byte == ledmc_pkg::CH_X) buf_fill = 0;
				end
			end
			ledmc_pkg::ACT_TICK: begin
				advance_timers();
			end
			ledmc_pkg::ACT_REFRESH: begin
				pins = render_pins(32'(rq.timer_count));
				if (rq.button_left && !held_left) begin
					mode = step_mode(mode, 1'b0);
					held_left = 1'b1;
					stepped = 1'b1;
				end
				if (rq.button_right && !held_right) begin
					mode = step_mode(mode, 1'b1);
					held_right = 1'b1;
					stepped = 1'b1;
				end
				if (!rq.button_left) held_left = 1'b0;
				if (!rq.button_right) held_right = 1'b0;
				if (stepped) pins = render_pins(32'(rq.timer_count));
			end
			default: ;
		endcase
		expected_views.push_back('{pins: pins, mode: mode});
	endfunction

	function void check_response(logic [ledmc_pkg::PINS_W-1:0] got_pins,
		logic [ledmc_pkg::MODE_W-1:0] got_mode);
		led_view_t want;
		if (expected_views.size() == 0) begin
			$error("result beat with nothing pending: led_pins %02h current_mode %0d",
				got_pins, got_mode);
			errors++;
			return;
		end
		want = expected_views.pop_front();
		results_seen++;
		if (got_pins !== want.pins) begin
			$error("led_pins: expected %02h, actual %02h", want.pins, got_pins);
			errors++;
		end
		if (got_mode !== want.mode) begin
			$error("current_mode: expected %0d, actual %0d", want.mode, got_mode);
			errors++;
		end
	endfunction

	function int pending_count();
		return expected_views.size();
	endfunction
endclass

module tb_top;

	localparam logic [ledmc_pkg::ACT_W-1:0] ACT_NOP = 2'd3;   // fourth action code, changes nothing
	localparam int TC_TOP          = 20000;         // top of the timer count range
	localparam int LONG_STALL      = 80;            // cycles of the long result hold-off
	localparam int SETTLE_CYCLES   = 4;             // margin after the last result beat
	localparam int DRAIN_LIMIT     = 500;
	localparam int TIMEOUT_NS      = 2_000_000;     // far beyond the slowest run

	logic clk;
	logic arst_n;

	ledmc_req_if req_bus();
	ledmc_rsp_if rsp_bus();
	ledmc_cfg_if cfg_bus();

	led_mode_controller_with_serial_commands_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	led_mode_scoreboard sb;

	// idle percentages for each side, changed between phases
	int req_idle_pct;
	int rsp_idle_pct;
	// one-shot request for the long result hold-off, consumed by the receiver
	bit long_stall_req;
	int commands_sent;
	// button levels presented on refresh beats
	bit btn_left_level;
	bit btn_right_level;
	logic [ledmc_pkg::BYTE_W-1:0] cmd_text[$];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#(TIMEOUT_NS);
		$display("led_mode_controller_with_serial_commands_core test failed");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off counted here
	initial begin : rsp_drive
		int stall_left;
		stall_left = 0;
		rsp_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_stall_req) begin
				stall_left = LONG_STALL;
				long_stall_req = 1'b0;
			end
			if (stall_left > 0) begin
				rsp_bus.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
			end
		end
	end

	// result monitor, sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
			sb.check_response(rsp_bus.led_pins, rsp_bus.current_mode);
		end
	end

	// one request beat: random gap, then hold valid until the block takes it
	task automatic send_request(input led_request_t rq);
		@(negedge clk);
		while ($urandom_range(99) < req_idle_pct) begin
			req_bus.valid <= 1'b0;
			@(negedge clk);
		end
		req_bus.valid        <= 1'b1;
		req_bus.action       <= rq.action;
		req_bus.rx_byte      <= rq.rx_byte;
		req_bus.timer_count  <= rq.timer_count;
		req_bus.button_left  <= rq.button_left;
		req_bus.button_right <= rq.button_right;
		do @(posedge clk); while (req_bus.ready !== 1'b1);
		sb.note_request(rq);
	endtask

	// unused fields carry random values so they get exercised too
	task automatic send_byte(input logic [ledmc_pkg::BYTE_W-1:0] b);
		led_request_t rq;
		rq = REQ_W'($urandom);
		rq.action = ledmc_pkg::ACT_BYTE;
		rq.rx_byte = b;
		send_request(rq);
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	task automatic send_tick();
		led_request_t rq;
		rq = REQ_W'($urandom);
		rq.action = ledmc_pkg::ACT_TICK;
		send_request(rq);
	endtask

	task automatic send_refresh(input int tc, input bit bl, input bit br);
		led_request_t rq;
		rq = REQ_W'($urandom);
		rq.action = ledmc_pkg::ACT_REFRESH;
		rq.timer_count = ledmc_pkg::TC_W'(tc);
		rq.button_left = bl;
		rq.button_right = br;
		send_request(rq);
	endtask

	task automatic write_reg(input logic [ledmc_pkg::CFG_IDX_W-1:0] idx,
		input logic [ledmc_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		sb.set_register(idx, value);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	// drop valid and wait until every result beat is back
	task automatic settle();
		@(negedge clk);
		req_bus.valid <= 1'b0;
		while (sb.pending_count() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_word(input string s);
		for (int i = 0; i < s.len(); i++) cmd_text.push_back(s[i]);
	endtask

	// mostly well-formed commands, some cut short, overlong or broken by a zero
	task automatic send_random_command();
		int kind;
		int r;
		int n;
		int pos;
		cmd_text.delete();
		if ($urandom_range(99) < 70) cmd_text.push_back(ledmc_pkg::CH_X);
		kind = $urandom_range(0, 9);
		case (kind)
			0, 1: push_word("forwards");
			2, 3: push_word("backward");
			4, 5: begin
				push_word("mode00");
				r = $urandom_range(0, 12);
				if (r <= 9) begin
					cmd_text.push_back(ledmc_pkg::CH_0);
					cmd_text.push_back(ledmc_pkg::CH_0 + ledmc_pkg::BYTE_W'(r));
				end else if (r == 10) begin
					cmd_text.push_back(ledmc_pkg::CH_1);
					cmd_text.push_back(ledmc_pkg::CH_0);
				end else if (r == 11) begin
					// mode above ten is not a command
					cmd_text.push_back(ledmc_pkg::CH_1);
					cmd_text.push_back(ledmc_pkg::CH_0 +
						ledmc_pkg::BYTE_W'($urandom_range(1, 9)));
				end else begin
					cmd_text.push_back(ledmc_pkg::CH_0);
					cmd_text.push_back(ledmc_pkg::BYTE_W'($urandom_range(0, 255)));
				end
			end
			6, 7: begin
				cmd_text.push_back(ledmc_pkg::CH_C);
				cmd_text.push_back(ledmc_pkg::CH_U);
				n = ($urandom_range(99) < 70) ? ledmc_pkg::PINS_W
					: $urandom_range(0, ledmc_pkg::PINS_W);
				repeat (n) begin
					r = $urandom_range(99);
					if (r < 50) cmd_text.push_back(ledmc_pkg::CH_1);
					else if (r < 90) cmd_text.push_back(ledmc_pkg::CH_0);
					else cmd_text.push_back(ledmc_pkg::BYTE_W'($urandom_range(0, 255)));
				end
			end
			8: begin
				// lowercase noise, may hold its own restart or execute
				repeat ($urandom_range(1, 10))
					cmd_text.push_back(ledmc_pkg::BYTE_W'($urandom_range(8'h61, 8'h7A)));
			end
			default: begin
				// zero byte cuts the text short
				push_word("forwards");
				pos = cmd_text.size() - 1 - $urandom_range(0, 7);
				cmd_text[pos] = 8'h00;
			end
		endcase
		// overlong text: bytes past a full buffer are dropped
		if (kind <= 7 && $urandom_range(99) < 15) begin
			repeat ($urandom_range(1, 4))
				cmd_text.push_back(ledmc_pkg::BYTE_W'($urandom_range(8'h61, 8'h77)));
		end
		if ($urandom_range(99) < 90) cmd_text.push_back(ledmc_pkg::CH_Z);
		foreach (cmd_text[i]) send_byte(cmd_text[i]);
		commands_sent++;
	endtask

	task automatic send_random_refresh();
		int tc;
		if ($urandom_range(99) < 25) btn_left_level = ~btn_left_level;
		if ($urandom_range(99) < 25) btn_right_level = ~btn_right_level;
		case ($urandom_range(0, 3))
			0: tc = $urandom_range(0, TC_TOP);
			1: begin
				// right at the fade level, where breathing pins switch
				tc = int'(sb.fade_level);
				tc += $urandom_range(0, 2);
				tc -= 1;
				if (tc < 0) tc = 0;
				if (tc > TC_TOP) tc = TC_TOP;
			end
			2: tc = ($urandom_range(1) != 0) ? TC_TOP : $urandom_range(16384, TC_TOP);
			default: tc = $urandom_range(0, 1023);
		endcase
		send_refresh(tc, btn_left_level, btn_right_level);
	endtask

	task automatic run_random(input int n_items);
		int start;
		int pick;
		led_request_t rq;
		start = sb.requests_seen;
		while (sb.requests_seen - start < n_items) begin
			pick = $urandom_range(99);
			if (pick < 30) begin
				send_random_command();
			end else if (pick < 52) begin
				repeat ($urandom_range(1, 6)) send_tick();
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 4)) send_random_refresh();
			end else if (pick < 96) begin
				repeat ($urandom_range(1, 3))
					send_byte(ledmc_pkg::BYTE_W'($urandom_range(0, 255)));
			end else begin
				rq = REQ_W'($urandom);
				rq.action = ACT_NOP;
				send_request(rq);
			end
		end
	endtask

	// short directed sequence: button wrap, short custom text, cycle clear, cycle boundary
	task automatic run_directed();
		led_request_t rq;
		send_refresh(TC_TOP, 1'b1, 1'b0);   // left press wraps off down to nine
		send_refresh(0, 1'b1, 1'b1);        // left still held, right press wraps up to off
		send_refresh(0, 1'b0, 1'b0);        // both released
		send_string("cu1z");                // custom text cut short after one pin bit
		send_refresh(0, 1'b0, 1'b0);
		send_tick();
		send_tick();
		send_string("xmode0007z");          // colour cycle, clears the cycle time
		send_refresh(TC_TOP, 1'b0, 1'b0);
		send_tick();                        // lands on a segment boundary
		send_refresh(0, 1'b0, 1'b0);
		rq = '1;
		rq.action = ACT_NOP;
		send_request(rq);
	endtask

	initial begin : stimulus
		int waited;
		sb = new();
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.action = ledmc_pkg::ACT_BYTE;
		req_bus.rx_byte = '0;
		req_bus.timer_count = '0;
		req_bus.button_left = 1'b0;
		req_bus.button_right = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = ledmc_pkg::REG_FADE_STEP;
		cfg_bus.data = '0;
		long_stall_req = 1'b0;
		commands_sent = 0;
		btn_left_level = 1'b0;
		btn_right_level = 1'b0;

		// first mix: sender rarely idle, receiver often stalls
		req_idle_pct = 11;
		rsp_idle_pct = 57;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// both steps at their top values
		write_reg(ledmc_pkg::REG_FADE_STEP, ledmc_pkg::CFG_DATA_W'(1000));
		write_reg(ledmc_pkg::REG_CYCLE_STEP, ledmc_pkg::CFG_DATA_W'(2000));
		run_directed();
		settle();

		write_reg(ledmc_pkg::REG_FADE_STEP, ledmc_pkg::CFG_DATA_W'($urandom_range(150, 1000)));
		write_reg(ledmc_pkg::REG_CYCLE_STEP, ledmc_pkg::CFG_DATA_W'($urandom_range(1, 2000)));
		run_random(250);
		settle();

		// second mix swaps the sides; both steps at their lowest
		req_idle_pct = 57;
		rsp_idle_pct = 11;
		write_reg(ledmc_pkg::REG_FADE_STEP, ledmc_pkg::CFG_DATA_W'(1));
		write_reg(ledmc_pkg::REG_CYCLE_STEP, ledmc_pkg::CFG_DATA_W'(1));
		run_random(150);
		settle();

		// no idling at all, random steps, and one long result hold-off
		req_idle_pct = 0;
		rsp_idle_pct = 0;
		write_reg(ledmc_pkg::REG_FADE_STEP, ledmc_pkg::CFG_DATA_W'($urandom_range(1, 1000)));
		write_reg(ledmc_pkg::REG_CYCLE_STEP, ledmc_pkg::CFG_DATA_W'($urandom_range(1, 2000)));
		long_stall_req = 1'b1;
		run_random(330);

		// drain what is still in flight, with a bound
		@(negedge clk);
		req_bus.valid <= 1'b0;
		waited = 0;
		while (sb.pending_count() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.pending_count() != 0) begin
			$error("%0d result beats never arrived", sb.pending_count());
			sb.errors++;
		end

		$display("covered %0d request beats with %0d serial commands, four step settings",
			sb.requests_seen, commands_sent);
		$display("compared %0d result beats under three idle mixes, %0d mismatches",
			sb.results_seen, sb.errors);
		if (sb.errors == 0) begin
			$display("led_mode_controller_with_serial_commands_core test passed");
		end else begin
			$display("led_mode_controller_with_serial_commands_core test failed");
		end
		$finish;
	end

endmodule
